// ===== src/snv_pkg.sv =====
// Shared types and constants for the surface nets cell vertex block.
// No dependencies; imported by every module of the block.
`default_nettype none
package snv_pkg;

  localparam int SAMPLE_W = 16;
  localparam int Q_W      = 17;
  localparam int SUM_W    = 20;
  localparam int CNT_W    = 4;
  localparam int NUM_EDGE = 12;
  localparam int DIV_BITS = 16;
  localparam int LANE_LAT = DIV_BITS + 2;

  localparam logic [Q_W-1:0] Q_ONE  = 17'h10000;
  localparam logic [Q_W-1:0] Q_HALF = 17'h08000;

  // corner position bits, bit c is corner c
  localparam logic [7:0] CPX = 8'b0110_0110;
  localparam logic [7:0] CPY = 8'b1111_0000;
  localparam logic [7:0] CPZ = 8'b1100_1100;

  localparam int EDGE_A [NUM_EDGE] = '{0, 1, 2, 3, 4, 5, 6, 7, 0, 1, 2, 3};
  localparam int EDGE_B [NUM_EDGE] = '{1, 2, 3, 0, 5, 6, 7, 4, 4, 5, 6, 7};

  typedef struct packed {
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [7:0]  cell_z;
    logic signed [SAMPLE_W-1:0] corner_0;
    logic signed [SAMPLE_W-1:0] corner_1;
    logic signed [SAMPLE_W-1:0] corner_2;
    logic signed [SAMPLE_W-1:0] corner_3;
    logic signed [SAMPLE_W-1:0] corner_4;
    logic signed [SAMPLE_W-1:0] corner_5;
    logic signed [SAMPLE_W-1:0] corner_6;
    logic signed [SAMPLE_W-1:0] corner_7;
  } in_t;

  typedef struct packed {
    logic [7:0]     out_cell_x;
    logic [7:0]     out_cell_y;
    logic [7:0]     out_cell_z;
    logic [7:0]     inside_mask;
    logic           has_vertex;
    logic [CNT_W-1:0] crossing_count;
    logic [Q_W-1:0] vertex_x;
    logic [Q_W-1:0] vertex_y;
    logic [Q_W-1:0] vertex_z;
  } out_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] cx;
    logic [7:0] cy;
    logic [7:0] cz;
    logic [7:0] mask;
    logic       straddle;
  } ctl_t;

  typedef struct packed {
    logic           crossed;
    logic [Q_W-1:0] px;
    logic [Q_W-1:0] py;
    logic [Q_W-1:0] pz;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== src/snv_lane.sv =====
// One edge lane: crossing parameter by a bit-per-stage divider, then the point.
// Depends on snv_pkg.
`default_nettype none
module snv_lane
  import snv_pkg::*;
#(
  parameter int A = 0,
  parameter int B = 1
) (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic signed [SAMPLE_W-1:0] iso,
  input  wire logic signed [SAMPLE_W-1:0] sa,
  input  wire logic signed [SAMPLE_W-1:0] sb,
  input  wire logic                       crossed,
  output lane_res_t                       res
);

  logic signed [SAMPLE_W:0] num, den;
  logic [SAMPLE_W:0] un, ud;
  logic              fix;
  logic [Q_W-1:0]    fval;

  assign num = $signed({iso[SAMPLE_W-1], iso}) - $signed({sa[SAMPLE_W-1], sa});
  assign den = $signed({sb[SAMPLE_W-1], sb}) - $signed({sa[SAMPLE_W-1], sa});
  assign un  = num[SAMPLE_W] ? 17'(-num) : 17'(num);
  assign ud  = den[SAMPLE_W] ? 17'(-den) : 17'(den);

  always_comb begin
    fix  = 1'b1;
    fval = '0;
    if (den == '0) begin
      fval = Q_HALF;
    end else if (num == '0) begin
      fval = '0;
    end else if (num[SAMPLE_W] != den[SAMPLE_W]) begin
      fval = '0;
    end else if (un >= ud) begin
      fval = Q_ONE;
    end else begin
      fix = 1'b0;
    end
  end

  logic [SAMPLE_W:0]   rem_r  [DIV_BITS+1];
  logic [SAMPLE_W:0]   ud_r   [DIV_BITS+1];
  logic [DIV_BITS-1:0] quo_r  [DIV_BITS+1];
  logic                fix_r  [DIV_BITS+1];
  logic [Q_W-1:0]      fval_r [DIV_BITS+1];
  logic                crs_r  [DIV_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= un;
      ud_r[0]   <= ud;
      quo_r[0]  <= '0;
      fix_r[0]  <= fix;
      fval_r[0] <= fval;
      crs_r[0]  <= crossed;
    end
  end

  for (genvar i = 0; i < DIV_BITS; i++) begin : g_div
    logic [SAMPLE_W+1:0] r2;
    logic                ge;
    assign r2 = {rem_r[i], 1'b0};
    assign ge = r2 >= {1'b0, ud_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= ge ? 17'(r2 - {1'b0, ud_r[i]}) : 17'(r2);
        ud_r[i+1]   <= ud_r[i];
        quo_r[i+1]  <= {quo_r[i][DIV_BITS-2:0], ge};
        fix_r[i+1]  <= fix_r[i];
        fval_r[i+1] <= fval_r[i];
        crs_r[i+1]  <= crs_r[i];
      end
    end
  end

  logic [Q_W-1:0] t;
  assign t = fix_r[DIV_BITS] ? fval_r[DIV_BITS] : {1'b0, quo_r[DIV_BITS]};

  function automatic logic [Q_W-1:0] coord(input logic pa, input logic pb,
                                           input logic [Q_W-1:0] tv);
    logic [Q_W-1:0] v;
    if (pa == pb) v = pa ? Q_ONE : '0;
    else if (!pa) v = tv;
    else          v = Q_ONE - tv;
    return v;
  endfunction

  lane_res_t res_r;
  always_ff @(posedge clk) begin
    if (en) begin
      res_r.crossed <= crs_r[DIV_BITS];
      res_r.px <= crs_r[DIV_BITS] ? coord(CPX[A], CPX[B], t) : '0;
      res_r.py <= crs_r[DIV_BITS] ? coord(CPY[A], CPY[B], t) : '0;
      res_r.pz <= crs_r[DIV_BITS] ? coord(CPZ[A], CPZ[B], t) : '0;
    end
  end
  assign res = res_r;

endmodule
`default_nettype wire

// ===== src/snv_merge.sv =====
// Merge stage: sums the lane points, counts crossings, divides by the count.
// Depends on snv_pkg.
`default_nettype none
module snv_merge
  import snv_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire ctl_t      ctl,
  input  wire lane_res_t lanes [NUM_EDGE],
  output logic           valid,
  output out_t           data
);

  localparam int H = NUM_EDGE / 2;

  logic [SUM_W-1:0] hx [2], hy [2], hz [2];
  logic [CNT_W-1:0] cnt;

  always_comb begin
    cnt = '0;
    for (int h = 0; h < 2; h++) begin
      hx[h] = '0;
      hy[h] = '0;
      hz[h] = '0;
      for (int e = 0; e < H; e++) begin
        hx[h] = hx[h] + SUM_W'(lanes[h*H+e].px);
        hy[h] = hy[h] + SUM_W'(lanes[h*H+e].py);
        hz[h] = hz[h] + SUM_W'(lanes[h*H+e].pz);
        cnt   = cnt + CNT_W'(lanes[h*H+e].crossed);
      end
    end
  end

  ctl_t             c1_r;
  logic [SUM_W-1:0] hx_r [2], hy_r [2], hz_r [2];
  logic [CNT_W-1:0] cnt1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
    end else if (en) begin
      c1_r <= ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hx_r <= hx;
      hy_r <= hy;
      hz_r <= hz;
      cnt1_r <= cnt;
    end
  end

  ctl_t             cd_r  [SUM_W+1];
  logic [CNT_W-1:0] cntd_r[SUM_W+1];
  logic [SUM_W-1:0] dv_r  [SUM_W+1][3];
  logic [SUM_W-1:0] qt_r  [SUM_W+1][3];
  logic [CNT_W-1:0] rm_r  [SUM_W+1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cd_r[0] <= '0;
    end else if (en) begin
      cd_r[0] <= c1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cntd_r[0]  <= cnt1_r;
      dv_r[0][0] <= hx_r[0] + hx_r[1];
      dv_r[0][1] <= hy_r[0] + hy_r[1];
      dv_r[0][2] <= hz_r[0] + hz_r[1];
      for (int a = 0; a < 3; a++) begin
        qt_r[0][a] <= '0;
        rm_r[0][a] <= '0;
      end
    end
  end

  for (genvar i = 0; i < SUM_W; i++) begin : g_div
    logic [CNT_W:0] r2 [3];
    logic           ge [3];
    for (genvar a = 0; a < 3; a++) begin : g_ax
      assign r2[a] = {rm_r[i][a], dv_r[i][a][SUM_W-1]};
      assign ge[a] = r2[a] >= {1'b0, cntd_r[i]};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cd_r[i+1] <= '0;
      end else if (en) begin
        cd_r[i+1] <= cd_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cntd_r[i+1] <= cntd_r[i];
        for (int a = 0; a < 3; a++) begin
          rm_r[i+1][a] <= ge[a] ? CNT_W'(r2[a] - {1'b0, cntd_r[i]}) : CNT_W'(r2[a]);
          dv_r[i+1][a] <= {dv_r[i][a][SUM_W-2:0], 1'b0};
          qt_r[i+1][a] <= {qt_r[i][a][SUM_W-2:0], ge[a]};
        end
      end
    end
  end

  logic nz;
  assign nz = cntd_r[SUM_W] != '0;

  assign valid               = cd_r[SUM_W].valid;
  assign data.out_cell_x     = cd_r[SUM_W].cx;
  assign data.out_cell_y     = cd_r[SUM_W].cy;
  assign data.out_cell_z     = cd_r[SUM_W].cz;
  assign data.inside_mask    = cd_r[SUM_W].mask;
  assign data.has_vertex     = cd_r[SUM_W].straddle;
  assign data.crossing_count = cntd_r[SUM_W];
  assign data.vertex_x       = nz ? qt_r[SUM_W][0][Q_W-1:0] : '0;
  assign data.vertex_y       = nz ? qt_r[SUM_W][1][Q_W-1:0] : '0;
  assign data.vertex_z       = nz ? qt_r[SUM_W][2][Q_W-1:0] : '0;

endmodule
`default_nettype wire

// ===== src/surface_nets_cell_vertex.sv =====
// Surface nets cell vertex: turns each accepted cell word into one result word.
// Throughput one cell per cycle; the whole pipeline holds while a result is stalled.
// Most of the pipeline lies in the 16-stage edge dividers and the 20-stage count divider.
// Synchronous active-low reset clears valids and sets the iso level register iso_r to 0.
// Depends on snv_pkg, snv_lane, snv_merge.
`default_nettype none
module surface_nets_cell_vertex
  import snv_pkg::*;
#(
  parameter int GRID_CELLS = 256
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_t         in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_t             out_data,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic signed [SAMPLE_W-1:0] iso_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iso_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2]) begin
      iso_r <= cfg_pwdata[SAMPLE_W-1:0];
    end
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? '0 : {{(32-SAMPLE_W){iso_r[SAMPLE_W-1]}}, iso_r};

  logic signed [SAMPLE_W-1:0] s [8];
  assign s[0] = in_data.corner_0;
  assign s[1] = in_data.corner_1;
  assign s[2] = in_data.corner_2;
  assign s[3] = in_data.corner_3;
  assign s[4] = in_data.corner_4;
  assign s[5] = in_data.corner_5;
  assign s[6] = in_data.corner_6;
  assign s[7] = in_data.corner_7;

  logic [7:0] mask;
  logic       in_grid, straddle;
  always_comb begin
    for (int c = 0; c < 8; c++) mask[c] = s[c] > iso_r;
  end
  assign in_grid  = ({1'b0, in_data.cell_x} < 9'(GRID_CELLS)) &&
                    ({1'b0, in_data.cell_y} < 9'(GRID_CELLS)) &&
                    ({1'b0, in_data.cell_z} < 9'(GRID_CELLS));
  assign straddle = in_grid && (mask != 8'h00) && (mask != 8'hFF);

  lane_res_t lres [NUM_EDGE];
  for (genvar e = 0; e < NUM_EDGE; e++) begin : g_lane
    snv_lane #(.A(EDGE_A[e]), .B(EDGE_B[e])) u_lane (
      .clk     (clk),
      .en      (en),
      .iso     (iso_r),
      .sa      (s[EDGE_A[e]]),
      .sb      (s[EDGE_B[e]]),
      .crossed (straddle && (mask[EDGE_A[e]] != mask[EDGE_B[e]])),
      .res     (lres[e])
    );
  end

  ctl_t ctl_r [LANE_LAT];
  for (genvar i = 0; i < LANE_LAT; i++) begin : g_ctl
    ctl_t src;
    if (i == 0) begin : g_src0
      assign src = '{valid: in_valid, cx: in_data.cell_x, cy: in_data.cell_y,
                     cz: in_data.cell_z, mask: mask, straddle: straddle};
    end else begin : g_srcn
      assign src = ctl_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i] <= src;
      end
    end
  end

  snv_merge u_merge (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl   (ctl_r[LANE_LAT-1]),
    .lanes (lres),
    .valid (out_valid),
    .data  (out_data)
  );

endmodule
`default_nettype wire
